// ===== rtl/bblc_pkg.sv =====
// ----------------------------------------------------------------------------
// bblc_pkg: shared types and constants for the byte budget LRU cache
// Operation codes, table geometry, controller states and command bundles.
// ----------------------------------------------------------------------------
package bblc_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 32;
  localparam int SLOT_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int TOTAL_BITS = 36;
  localparam logic [31:0] BUDGET_RESET = 32'd67108864;

  localparam logic [2:0] OP_PUT      = 3'd0;
  localparam logic [2:0] OP_GET      = 3'd1;
  localparam logic [2:0] OP_REMOVE   = 3'd2;
  localparam logic [2:0] OP_CLEAR    = 3'd3;
  localparam logic [2:0] OP_CONTAINS = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DROP,
    ST_EVICT,
    ST_INSERT,
    ST_EXEC,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // latch the input item, clear per-item flags
    logic search;   // compare key against all slots, record match
    logic drop;     // drop the matched slot
    logic evict;    // drop the LRU slot, count an eviction
    logic insert;   // insert the new entry as most recent
    logic exec;     // get, remove, clear or probe
    logic publish;  // write the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       match;
    logic       over_budget;  // live entries remain and total + size > budget
    logic       full;
  } dp_stat_t;

endpackage

// ===== rtl/byte_budget_lru_cache_core.sv =====
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_core: size-weighted LRU cache with a byte budget
// Get/remove/clear/probe go through search, exec and done; put goes through
// search, a drop of the matching entry if any, the eviction loop and insert,
// with one eviction per cycle in the eviction loop.
// Throughput: one item at a time; a new item is taken while the last result
// waits in the output register. Reset empties the table, budget = 64 MiB.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_core import bblc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            operation,
  input  logic [31:0]           key_tag,
  input  logic [31:0]           entry_size,
  input  logic [31:0]           entry_handle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [31:0]           found_handle,
  output logic [15:0]           access_count,
  output logic [TOTAL_BITS-1:0] used_bytes,
  output logic [CNT_BITS-1:0]   entry_count,
  output logic [CNT_BITS-1:0]   evicted_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy, in_fire, out_busy;
  logic [31:0] budget;

  // config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) budget <= BUDGET_RESET;
    else if (psel && penable && pwrite && paddr == 2'd0) budget <= pwdata;
  end
  assign prdata = (paddr == 2'd0) ? budget : 32'd0;

  // handshake
  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.publish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  bblc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_busy),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  bblc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .budget(budget),
    .in_op(operation), .in_key(key_tag), .in_size(entry_size),
    .in_handle(entry_handle),
    .res_hit(hit), .res_handle(found_handle), .res_count(access_count),
    .res_used(used_bytes), .res_entries(entry_count),
    .res_evicted(evicted_count)
  );

endmodule

// ===== rtl/bblc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bblc_ctrl: operation sequencer
// Steps one item through search, drop, eviction, insert or exec, and result publish.
// ----------------------------------------------------------------------------
module bblc_ctrl import bblc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     out_busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire) state_next = ST_SEARCH;
      ST_SEARCH: begin
        if (stat.op == OP_PUT) state_next = stat.match ? ST_DROP : ST_EVICT;
        else                   state_next = ST_EXEC;
      end
      ST_DROP:   state_next = ST_EVICT;
      ST_EVICT:  if (!stat.over_budget && !stat.full) state_next = ST_INSERT;
      ST_INSERT: state_next = ST_DONE;
      ST_EXEC:   state_next = ST_DONE;
      ST_DONE:   if (!out_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = in_fire;
      end
      ST_SEARCH: cmd.search = 1'b1;
      ST_DROP:   cmd.drop   = 1'b1;
      ST_EVICT:  cmd.evict  = stat.over_budget || stat.full;
      ST_INSERT: cmd.insert = 1'b1;
      ST_EXEC:   cmd.exec   = 1'b1;
      ST_DONE:   cmd.publish = !out_busy;
      default:   busy = 1'b1;
    endcase
  end

endmodule

// ===== rtl/bblc_datapath.sv =====
// ----------------------------------------------------------------------------
// bblc_datapath: entry table, recency ranks and byte total
// Slot registers with per-slot rank update cells and one result register.
// ----------------------------------------------------------------------------
module bblc_datapath import bblc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [31:0]           budget,
  input  logic [2:0]            in_op,
  input  logic [31:0]           in_key,
  input  logic [31:0]           in_size,
  input  logic [31:0]           in_handle,
  output logic                  res_hit,
  output logic [31:0]           res_handle,
  output logic [15:0]           res_count,
  output logic [TOTAL_BITS-1:0] res_used,
  output logic [CNT_BITS-1:0]   res_entries,
  output logic [CNT_BITS-1:0]   res_evicted
);

  logic [CAPACITY-1:0] valid;
  logic [KEY_BITS-1:0] keys    [CAPACITY];
  logic [31:0]         sizes   [CAPACITY];
  logic [31:0]         handles [CAPACITY];
  logic [15:0]         counts  [CAPACITY];
  logic [SLOT_BITS-1:0] ranks  [CAPACITY];
  logic [TOTAL_BITS-1:0] total;
  logic [CNT_BITS-1:0]   live;

  // latched item
  logic [2:0]          op;
  logic [KEY_BITS-1:0] key;
  logic [31:0]         size, handle;
  logic                match, hit_flag;
  logic [SLOT_BITS-1:0] mslot;
  logic [CNT_BITS-1:0]  evicted;
  logic [31:0]          out_handle;
  logic [15:0]          out_count;

  // search: parallel compare, priority encode lowest slot
  logic [CAPACITY-1:0]  eq;
  logic                 any_eq;
  logic [SLOT_BITS-1:0] eq_slot;
  always_comb begin
    any_eq  = 1'b0;
    eq_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      eq[i] = valid[i] && (keys[i] == key);
      if (eq[i]) begin
        any_eq  = 1'b1;
        eq_slot = SLOT_BITS'(i);
      end
    end
  end

  // LRU slot and first free slot
  logic [SLOT_BITS-1:0] lru_slot, free_slot;
  logic [SLOT_BITS-1:0] last_rank;
  assign last_rank = SLOT_BITS'(live - CNT_BITS'(1));
  always_comb begin
    lru_slot  = '0;
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (valid[i] && ranks[i] == last_rank) lru_slot = SLOT_BITS'(i);
      if (!valid[i]) free_slot = SLOT_BITS'(i);
    end
  end

  // status; match is the live compare, read by the controller during search
  logic [TOTAL_BITS:0] need;
  assign need = {1'b0, total} + (TOTAL_BITS + 1)'(size);
  assign stat.op          = op;
  assign stat.match       = any_eq;
  assign stat.over_budget = (live != '0) && (need > (TOTAL_BITS + 1)'(budget));
  assign stat.full        = (live == CNT_BITS'(CAPACITY));

  // slot chosen for drop: matched slot for drop/remove, LRU for evict
  logic                 do_drop;
  logic [SLOT_BITS-1:0] dslot;
  assign do_drop = cmd.drop || cmd.evict ||
                   (cmd.exec && op == OP_REMOVE && match);
  assign dslot   = cmd.evict ? lru_slot : mslot;
  logic do_touch;
  assign do_touch = cmd.exec && op == OP_GET && match;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      total <= '0;
      live  <= '0;
    end else if (do_drop) begin
      valid[dslot] <= 1'b0;
      total <= total - TOTAL_BITS'(sizes[dslot]);
      live  <= live - CNT_BITS'(1);
    end else if (cmd.insert) begin
      valid[free_slot] <= 1'b1;
      total <= total + TOTAL_BITS'(size);
      live  <= live + CNT_BITS'(1);
    end else if (cmd.exec && op == OP_CLEAR) begin
      valid <= '0;
      total <= '0;
      live  <= '0;
    end
  end

  // per-slot rank cells and payload stores
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_drop) begin
        if (valid[i] && SLOT_BITS'(i) != dslot && ranks[i] > ranks[dslot])
          ranks[i] <= ranks[i] - SLOT_BITS'(1);
      end else if (cmd.insert) begin
        if (valid[i]) ranks[i] <= ranks[i] + SLOT_BITS'(1);
      end else if (do_touch) begin
        if (SLOT_BITS'(i) == mslot) ranks[i] <= '0;
        else if (valid[i] && ranks[i] < ranks[mslot])
          ranks[i] <= ranks[i] + SLOT_BITS'(1);
      end
    end
    if (cmd.insert) begin
      keys[free_slot]    <= key;
      sizes[free_slot]   <= size;
      handles[free_slot] <= handle;
      counts[free_slot]  <= '0;
      ranks[free_slot]   <= '0;
    end
    if (do_touch && counts[mslot] != 16'hFFFF)
      counts[mslot] <= counts[mslot] + 16'd1;
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= in_op;
      key     <= in_key[KEY_BITS-1:0];
      size    <= in_size;
      handle  <= in_handle;
      evicted <= '0;
      out_handle <= '0;
      out_count  <= '0;
    end
    if (cmd.search) begin
      match <= any_eq;
      mslot <= eq_slot;
      hit_flag <= any_eq && (op == OP_PUT || op == OP_GET ||
                             op == OP_REMOVE || op == OP_CONTAINS);
    end
    if (cmd.evict) evicted <= evicted + CNT_BITS'(1);
    if (do_touch) begin
      out_handle <= handles[mslot];
      out_count  <= (counts[mslot] == 16'hFFFF) ? 16'hFFFF : counts[mslot] + 16'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res_hit     <= hit_flag;
      res_handle  <= out_handle;
      res_count   <= out_count;
      res_used    <= total;
      res_entries <= live;
      res_evicted <= evicted;
    end
  end

endmodule
